>>> rtl/blg_pkg.sv
// Shared constants, types and queue entry layout for the line generator.
package blg_pkg;

    localparam int COORD_BITS     = 12;
    localparam int DELTA2_BITS    = COORD_BITS + 1;
    localparam int ERR_BITS       = COORD_BITS + 2;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_BITS = 2;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        logic                   is_tick;
        logic                   active;
        logic                   x_major;
        coord_t                 major_pos;
        coord_t                 major_end;
        coord_t                 minor_pos;
        logic                   major_dir;
        logic                   minor_dir;
        logic [COORD_BITS-1:0]  err_init;
        logic [DELTA2_BITS-1:0] incr;
        logic [DELTA2_BITS-1:0] limit;
    } queue_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

>>> rtl/bresenham_line_generator_core.sv
// Top level of the Bresenham line generator: front end, beat queue and stepper.
//
//   channel   direction  handshake             payload
//   input     in         in_valid / in_ready   cmd, start_x, start_y, end_x, end_y
//   output    out        out_valid / out_ready pixel_x, pixel_y, last_pixel
//
// One input beat is taken per cycle while the four-entry queue has room.
// The stepper retires one queued beat per cycle, but a stalled output holds ticks
// on an active line; such a tick yields one pixel via the queue and output register.
// Reset is asynchronous and clears all control state; no clearing pass is needed.
// The queue absorbs up to four input beats while the output is stalled.
module bresenham_line_generator_core
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic            cmd,
    input  blg_pkg::coord_t start_x,
    input  blg_pkg::coord_t start_y,
    input  blg_pkg::coord_t end_x,
    input  blg_pkg::coord_t end_y,
    output logic            out_valid,
    input  logic            out_ready,
    output blg_pkg::coord_t pixel_x,
    output blg_pkg::coord_t pixel_y,
    output logic            last_pixel
);

    blg_pkg::queue_status_t q_status;
    blg_pkg::queue_entry_t  push_entry;
    blg_pkg::queue_entry_t  head_entry;
    logic                   push;
    logic                   pop;

    blg_front u_front
    (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd        (cmd),
        .start_x    (start_x),
        .start_y    (start_y),
        .end_x      (end_x),
        .end_y      (end_y),
        .q_status   (q_status),
        .push       (push),
        .push_entry (push_entry)
    );

    blg_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_entry (head_entry),
        .status     (q_status)
    );

    blg_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_entry (head_entry),
        .q_status   (q_status),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .last_pixel (last_pixel)
    );

endmodule

>>> rtl/blg_front.sv
// Front end: accepts input beats, classifies them and computes line setup.
module blg_front
(
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  cmd,
    input  blg_pkg::coord_t       start_x,
    input  blg_pkg::coord_t       start_y,
    input  blg_pkg::coord_t       end_x,
    input  blg_pkg::coord_t       end_y,
    input  blg_pkg::queue_status_t q_status,
    output logic                  push,
    output blg_pkg::queue_entry_t push_entry
);

    logic signed [blg_pkg::COORD_BITS:0] dx;
    logic signed [blg_pkg::COORD_BITS:0] dy;
    logic signed [blg_pkg::COORD_BITS:0] dx_abs_wide;
    logic signed [blg_pkg::COORD_BITS:0] dy_abs_wide;
    logic [blg_pkg::COORD_BITS-1:0]      adx;
    logic [blg_pkg::COORD_BITS-1:0]      ady;
    logic                                x_down;
    logic                                y_down;
    logic                                x_major;

    assign in_ready = !q_status.full;
    assign push     = in_valid && in_ready;

    always_comb
    begin
        dx          = (blg_pkg::COORD_BITS+1)'(end_x) - (blg_pkg::COORD_BITS+1)'(start_x);
        dy          = (blg_pkg::COORD_BITS+1)'(end_y) - (blg_pkg::COORD_BITS+1)'(start_y);
        x_down      = dx[blg_pkg::COORD_BITS];
        y_down      = dy[blg_pkg::COORD_BITS];
        dx_abs_wide = x_down ? -dx : dx;
        dy_abs_wide = y_down ? -dy : dy;
        adx         = dx_abs_wide[blg_pkg::COORD_BITS-1:0];
        ady         = dy_abs_wide[blg_pkg::COORD_BITS-1:0];
        x_major     = adx >= ady;

        push_entry.is_tick = (cmd == blg_pkg::CMD_TICK);
        push_entry.x_major = x_major;
        if (x_major)
        begin
            push_entry.major_pos = start_x;
            push_entry.major_end = end_x;
            push_entry.minor_pos = start_y;
            push_entry.major_dir = x_down;
            push_entry.minor_dir = y_down;
            push_entry.err_init  = adx;
            push_entry.incr      = {ady, 1'b0};
            push_entry.limit     = {adx, 1'b0};
        end
        else
        begin
            push_entry.major_pos = start_y;
            push_entry.major_end = end_y;
            push_entry.minor_pos = start_x;
            push_entry.major_dir = y_down;
            push_entry.minor_dir = x_down;
            push_entry.err_init  = ady;
            push_entry.incr      = {adx, 1'b0};
            push_entry.limit     = {ady, 1'b0};
        end
        push_entry.active = (push_entry.major_pos != push_entry.major_end);
    end

endmodule

>>> rtl/blg_queue.sv
// Short queue of classified beats between the front end and the stepper.
module blg_queue
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  blg_pkg::queue_entry_t  push_entry,
    input  logic                   pop,
    output blg_pkg::queue_entry_t  head_entry,
    output blg_pkg::queue_status_t status
);

    blg_pkg::queue_entry_t mem_reg [blg_pkg::QUEUE_DEPTH];

    logic [blg_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_reg;
    logic [blg_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_next;
    logic [blg_pkg::QUEUE_PTR_BITS-1:0] rd_ptr_reg;
    logic [blg_pkg::QUEUE_PTR_BITS-1:0] rd_ptr_next;
    logic [blg_pkg::QUEUE_PTR_BITS:0]   count_reg;
    logic [blg_pkg::QUEUE_PTR_BITS:0]   count_next;

    assign status.full  = (count_reg == (blg_pkg::QUEUE_PTR_BITS+1)'(blg_pkg::QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign head_entry   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

>>> rtl/blg_back.sv
// Back end: holds the line state, steps one pixel per tick on an active line and registers the result.
module blg_back
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  blg_pkg::queue_entry_t  head_entry,
    input  blg_pkg::queue_status_t q_status,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output blg_pkg::coord_t        pixel_x,
    output blg_pkg::coord_t        pixel_y,
    output logic                   last_pixel
);

    logic                            line_active_reg;
    logic                            x_major_reg;
    blg_pkg::coord_t                 major_pos_reg;
    blg_pkg::coord_t                 major_end_reg;
    blg_pkg::coord_t                 minor_pos_reg;
    logic                            major_dir_reg;
    logic                            minor_dir_reg;
    logic [blg_pkg::ERR_BITS-1:0]    err_reg;
    logic [blg_pkg::DELTA2_BITS-1:0] incr_reg;
    logic [blg_pkg::DELTA2_BITS-1:0] limit_reg;

    logic                            out_valid_reg;
    logic                            out_valid_next;
    blg_pkg::coord_t                 pixel_x_reg;
    blg_pkg::coord_t                 pixel_y_reg;
    logic                            last_pixel_reg;

    logic                            emit;
    blg_pkg::coord_t                 major_step;
    blg_pkg::coord_t                 minor_step;
    logic [blg_pkg::ERR_BITS-1:0]    err_sum;
    logic                            minor_move;
    logic                            last_step;

    assign pop = !q_status.empty
                 && (!head_entry.is_tick || !line_active_reg || !out_valid_reg || out_ready);
    assign emit = pop && head_entry.is_tick && line_active_reg;

    always_comb
    begin
        major_step = major_dir_reg ? major_pos_reg - 1'b1 : major_pos_reg + 1'b1;
        minor_step = minor_dir_reg ? minor_pos_reg - 1'b1 : minor_pos_reg + 1'b1;
        err_sum    = err_reg + blg_pkg::ERR_BITS'(incr_reg);
        minor_move = err_sum > blg_pkg::ERR_BITS'(limit_reg);
        last_step  = (major_step == major_end_reg);
        out_valid_next = emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_active_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop && !head_entry.is_tick)
            begin
                line_active_reg <= head_entry.active;
            end
            else if (emit)
            begin
                line_active_reg <= !last_step;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && !head_entry.is_tick)
        begin
            x_major_reg   <= head_entry.x_major;
            major_pos_reg <= head_entry.major_pos;
            major_end_reg <= head_entry.major_end;
            minor_pos_reg <= head_entry.minor_pos;
            major_dir_reg <= head_entry.major_dir;
            minor_dir_reg <= head_entry.minor_dir;
            err_reg       <= {2'b00, head_entry.err_init};
            incr_reg      <= head_entry.incr;
            limit_reg     <= head_entry.limit;
        end
        else if (emit)
        begin
            major_pos_reg <= major_step;
            if (minor_move)
            begin
                err_reg       <= err_sum - blg_pkg::ERR_BITS'(limit_reg);
                minor_pos_reg <= minor_step;
            end
            else
            begin
                err_reg <= err_sum;
            end
        end
        if (emit)
        begin
            pixel_x_reg    <= x_major_reg ? major_pos_reg : minor_pos_reg;
            pixel_y_reg    <= x_major_reg ? minor_pos_reg : major_pos_reg;
            last_pixel_reg <= last_step;
        end
    end

    assign out_valid  = out_valid_reg;
    assign pixel_x    = pixel_x_reg;
    assign pixel_y    = pixel_y_reg;
    assign last_pixel = last_pixel_reg;

`ifndef SYNTHESIS
    a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> out_valid_reg)
        else $error("tick on an active line did not produce an output beat");

    a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
        emit && last_step |=> !line_active_reg)
        else $error("line stayed active after its last pixel");

    a_active_not_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        line_active_reg |-> major_pos_reg != major_end_reg)
        else $error("active line sits on its end pixel");

    a_err_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        line_active_reg |-> err_reg <= blg_pkg::ERR_BITS'(limit_reg))
        else $error("error term exceeds its limit");
`endif

endmodule

>>> bench/tb_top.sv
// Self-checking testbench for the Bresenham line generator core.
module tb_top;

    typedef struct {
        blg_pkg::coord_t x;
        blg_pkg::coord_t y;
        logic            last;
    } pixel_t;

    class line_tracker_t;
        bit              active;
        bit              x_major;
        bit              major_dir;
        bit              minor_dir;
        blg_pkg::coord_t major_pos;
        blg_pkg::coord_t major_end;
        blg_pkg::coord_t minor_pos;
        int              err;
        int              incr;
        int              limit;
        pixel_t          pending_pixels[$];
        int              mismatches;

        function void take_beat(logic c, blg_pkg::coord_t sx, blg_pkg::coord_t sy,
                                blg_pkg::coord_t ex, blg_pkg::coord_t ey);
            int     dx;
            int     dy;
            int     adx;
            int     ady;
            pixel_t p;
            if (c == blg_pkg::CMD_LOAD)
            begin
                dx = int'(ex) - int'(sx);
                dy = int'(ey) - int'(sy);
                adx = (dx < 0) ? -dx : dx;
                ady = (dy < 0) ? -dy : dy;
                x_major = (adx >= ady);
                if (x_major)
                begin
                    major_pos = sx;
                    major_end = ex;
                    minor_pos = sy;
                    major_dir = (sx > ex);
                    minor_dir = (sy > ey);
                    err = adx;
                    incr = 2 * ady;
                    limit = 2 * adx;
                end
                else
                begin
                    major_pos = sy;
                    major_end = ey;
                    minor_pos = sx;
                    major_dir = (sy > ey);
                    minor_dir = (sx > ex);
                    err = ady;
                    incr = 2 * adx;
                    limit = 2 * ady;
                end
                active = (major_pos != major_end);
                return;
            end
            if (!active)
                return;
            p.x = x_major ? major_pos : minor_pos;
            p.y = x_major ? minor_pos : major_pos;
            major_pos = blg_pkg::coord_t'(major_dir ? int'(major_pos) - 1 : int'(major_pos) + 1);
            err += incr;
            if (err > limit)
            begin
                err -= limit;
                minor_pos = blg_pkg::coord_t'(minor_dir ? int'(minor_pos) - 1
                                                        : int'(minor_pos) + 1);
            end
            p.last = (major_pos == major_end);
            if (p.last)
                active = 1'b0;
            pending_pixels.push_back(p);
        endfunction

        function void match_pixel(blg_pkg::coord_t px, blg_pkg::coord_t py, logic last);
            pixel_t exp_pix;
            if (pending_pixels.size() == 0)
            begin
                $error("unexpected pixel beat: x %0d, y %0d, last %0b", px, py, last);
                mismatches++;
                return;
            end
            exp_pix = pending_pixels.pop_front();
            if (px !== exp_pix.x)
            begin
                $error("pixel_x: expected %0d, got %0d", exp_pix.x, px);
                mismatches++;
            end
            if (py !== exp_pix.y)
            begin
                $error("pixel_y: expected %0d, got %0d", exp_pix.y, py);
                mismatches++;
            end
            if (last !== exp_pix.last)
            begin
                $error("last_pixel: expected %0b, got %0b", exp_pix.last, last);
                mismatches++;
            end
        endfunction
    endclass

    localparam int QUIET_LIMIT = 2000;
    localparam int TARGET_BEATS = 1950;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            in_valid = 1'b0;
    logic            in_ready;
    logic            cmd = blg_pkg::CMD_LOAD;
    blg_pkg::coord_t start_x = '0;
    blg_pkg::coord_t start_y = '0;
    blg_pkg::coord_t end_x = '0;
    blg_pkg::coord_t end_y = '0;
    logic            out_valid;
    logic            out_ready = 1'b0;
    blg_pkg::coord_t pixel_x;
    blg_pkg::coord_t pixel_y;
    logic            last_pixel;

    line_tracker_t tracker = new();
    int            beats_sent = 0;
    int            send_idle_pct = 32;
    int            recv_idle_pct = 73;
    int            hold_left = 0;
    bit            long_hold_due = 1'b0;
    bit            long_hold_taken = 1'b0;

    bresenham_line_generator_core u_dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd        (cmd),
        .start_x    (start_x),
        .start_y    (start_y),
        .end_x      (end_x),
        .end_y      (end_y),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .last_pixel (last_pixel)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            tracker.match_pixel(pixel_x, pixel_y, last_pixel);
        if (long_hold_due && !long_hold_taken)
        begin
            hold_left = 64;
            long_hold_taken = 1'b1;
        end
        else if (hold_left == 0 && $urandom_range(499) == 0)
        begin
            hold_left = $urandom_range(70, 30);
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("bresenham_line_generator_core: mismatch");
        $finish;
    end

    function automatic blg_pkg::coord_t clamp_coord(int v);
        if (v > 2047)
            return blg_pkg::coord_t'(2047);
        if (v < -2048)
            return blg_pkg::coord_t'(-2048);
        return blg_pkg::coord_t'(v);
    endfunction

    task automatic send_beat(logic c, blg_pkg::coord_t sx, blg_pkg::coord_t sy,
                             blg_pkg::coord_t ex, blg_pkg::coord_t ey);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= c;
        start_x <= sx;
        start_y <= sy;
        end_x <= ex;
        end_y <= ey;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        tracker.take_beat(c, sx, sy, ex, ey);
        beats_sent++;
    endtask

    task automatic send_load(int sx, int sy, int ex, int ey);
        send_beat(blg_pkg::CMD_LOAD, blg_pkg::coord_t'(sx), blg_pkg::coord_t'(sy),
                  blg_pkg::coord_t'(ex), blg_pkg::coord_t'(ey));
    endtask

    task automatic send_ticks(int n);
        for (int i = 0; i < n; i++)
            send_beat(blg_pkg::CMD_TICK, blg_pkg::coord_t'($urandom),
                      blg_pkg::coord_t'($urandom), blg_pkg::coord_t'($urandom),
                      blg_pkg::coord_t'($urandom));
    endtask

    task automatic run_line(int span);
        blg_pkg::coord_t sx;
        blg_pkg::coord_t sy;
        blg_pkg::coord_t ex;
        blg_pkg::coord_t ey;
        int              adx;
        int              ady;
        int              ticks;
        sx = blg_pkg::coord_t'($urandom);
        sy = blg_pkg::coord_t'($urandom);
        ex = clamp_coord(int'(sx) + int'($urandom_range(2 * span)) - span);
        ey = clamp_coord(int'(sy) + int'($urandom_range(2 * span)) - span);
        adx = (ex > sx) ? int'(ex) - int'(sx) : int'(sx) - int'(ex);
        ady = (ey > sy) ? int'(ey) - int'(sy) : int'(sy) - int'(ey);
        ticks = ((adx > ady) ? adx : ady) + int'($urandom_range(2));
        if ($urandom_range(7) == 0)
            ticks = int'($urandom_range(ticks));
        send_load(int'(sx), int'(sy), int'(ex), int'(ey));
        send_ticks(ticks);
    endtask

    initial
    begin
        int pick;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_ticks(1);
        send_load(5, -5, 5, -5);
        send_ticks(2);
        send_load(0, 0, 3, 1);
        send_ticks(4);
        send_load(0, 0, -1, -3);
        send_ticks(3);
        send_load(0, 0, 2, -2);
        send_ticks(2);
        send_load(-2048, 2047, 2047, -2048);
        send_ticks(2);
        send_load(2047, -2048, -2048, 2047);
        send_ticks(1);
        send_load(-2048, -2048, -2048, 2047);
        send_ticks(1);

        while (beats_sent < TARGET_BEATS)
        begin
            if (beats_sent < TARGET_BEATS / 3)
            begin
                send_idle_pct = 32;
                recv_idle_pct = 73;
            end
            else if (beats_sent < 2 * TARGET_BEATS / 3)
            begin
                send_idle_pct = 73;
                recv_idle_pct = 32;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                if (!long_hold_due)
                begin
                    long_hold_due = 1'b1;
                    send_load(-100, 0, 100, 37);
                    send_ticks(200);
                end
            end
            pick = int'($urandom_range(199));
            if (pick == 0)
                run_line(300);
            else if (pick < 10)
            begin
                send_load(int'(blg_pkg::coord_t'($urandom)), int'(blg_pkg::coord_t'($urandom)),
                          int'(blg_pkg::coord_t'($urandom)), int'(blg_pkg::coord_t'($urandom)));
                send_ticks(int'($urandom_range(4)));
            end
            else if (pick < 30)
                run_line(60);
            else
                run_line(10);
        end
        in_valid <= 1'b0;

        while (tracker.pending_pixels.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (tracker.mismatches == 0)
            $display("bresenham_line_generator_core: match");
        else
            $display("bresenham_line_generator_core: mismatch");
        $finish;
    end
endmodule
